// ===== rtl/core/ihb_pkg.sv =====
// ----------------------------------------------------------------------------
// ihb_pkg - shared types and constants for the heat-bath spin flip engine
// Field widths, spin and store sizes, state encoding, function codes and the
// start address of each coefficient block for every active spin count.
// ----------------------------------------------------------------------------
package ihb_pkg;

   localparam int NUM_SPINS  = 16;
   localparam int COEF_DEPTH = 136;

   localparam int COEF_AW = $clog2(COEF_DEPTH);
   localparam int ADDR_W  = COEF_AW + 1;
   localparam int SPIN_IW = $clog2(NUM_SPINS);
   localparam int CNT_W   = $clog2(NUM_SPINS + 1);

   // request and response field widths
   localparam int FUNC_W  = 2;
   localparam int IDX_W   = 8;
   localparam int COEF_W  = 16;
   localparam int SPIN_W  = 16;
   localparam int POS_W   = 4;
   localparam int SCALE_W = 17;
   localparam int RAND_W  = 16;
   localparam int CFG_W   = 5;

   localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(16);

   // datapath widths
   localparam int ACC_W  = 21;
   localparam int MUL_AW = 34;
   localparam int MUL_BW = 18;
   localparam int PROD_W = MUL_AW + MUL_BW;

   // fixed-point constants of the logistic
   localparam int LOG2E_Q12 = 5909;
   localparam int POLY_C2   = 22512;
   localparam logic [27:0] POLY_C1 = 28'd176226304;   // 43024 * 4096
   localparam logic [16:0] ONE_Q16 = 17'd65536;
   localparam logic [40:0] ACC_LIMIT = 41'h1_0000_0000;

   localparam logic [FUNC_W-1:0] FN_WRITE = 2'd0;
   localparam logic [FUNC_W-1:0] FN_LOAD  = 2'd1;
   localparam logic [FUNC_W-1:0] FN_FLIP  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM,
      ST_DRAIN,
      ST_MUL_X,
      ST_CLAMP,
      ST_EXPF,
      ST_POLY,
      ST_EXP,
      ST_DECIDE,
      ST_FINISH
   } state_type;

   typedef logic [ADDR_W-1:0] pair_base_type [0:NUM_SPINS];

   // n*(n-1)/2: number of pair couplings, i.e. where the fields start
   function automatic pair_base_type calc_pair_base();
      pair_base_type t;
      for (int i = 0; i <= NUM_SPINS; i++) begin
         t[i] = ADDR_W'((i * (i - 1)) >> 1);
      end
      return t;
   endfunction

   localparam pair_base_type PAIR_BASE = calc_pair_base();

endpackage

// ===== rtl/core/ihb_if.sv =====
// ----------------------------------------------------------------------------
// ihb_if - request and response channels of the spin flip engine
// Valid/ready channels; a request moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface ihb_req_if;
   import ihb_pkg::*;

   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [IDX_W-1:0]    coef_index;
   logic signed [COEF_W-1:0] coef_value;
   logic [SPIN_W-1:0]   spin_word;
   logic [POS_W-1:0]    spin_pos;
   logic [SCALE_W-1:0]  anneal_scale;
   logic [RAND_W-1:0]   random_u;

   modport source (
      output valid, func, coef_index, coef_value, spin_word, spin_pos,
             anneal_scale, random_u,
      input  ready
   );
   modport sink (
      input  valid, func, coef_index, coef_value, spin_word, spin_pos,
             anneal_scale, random_u,
      output ready
   );
endinterface

interface ihb_rsp_if;
   import ihb_pkg::*;

   logic              valid;
   logic              ready;
   logic [SPIN_W-1:0] spins;
   logic              flipped;

   modport source (output valid, spins, flipped, input ready);
   modport sink   (input  valid, spins, flipped, output ready);
endinterface

// ===== rtl/core/ising_heat_bath_spin_flip.sv =====
// ----------------------------------------------------------------------------
// ising_heat_bath_spin_flip - heat-bath single spin flip engine
// Holds the spin vector and a Q4.12 coefficient store; writes coefficients,
// loads spins and evaluates proposed flips against a caller's random value.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one request: coefficient write, spin load or flip
//   proposal. rsp_chan returns one response per request: spin vector after
//   it and whether a flip was made. csr_we/csr_wdata set the active spin
//   count n; write it only while no request is in flight.
//   Requests are taken one at a time; req_chan.ready is high only when idle.
//   A write, a load or a flip of a spin outside n goes from acceptance to the
//   finish state, which registers its response as the block turns idle again.
//   A flip reads one coefficient per active spin from the store RAM
//   (pipelined behind the registered read), then runs its steps through the
//   shared multiplier: scale, exponent, polynomial, and the acceptance test
//   done as a multiply against 2^32.
//   A stalled response sits in the output register while the next request
//   is already worked on; that one finishes only once the register frees.
//   Reset clears the spin vector, sets n to 16 and empties the output.
//   Coefficients are not cleared and must be written before use.
// ----------------------------------------------------------------------------
module ising_heat_bath_spin_flip (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [ihb_pkg::CFG_W-1:0]  csr_wdata,
   ihb_req_if.sink                    req_chan,
   ihb_rsp_if.source                  rsp_chan
);
   import ihb_pkg::*;

   state_type state_ff, state_in;

   logic [CFG_W-1:0]   active_ff, active_in;
   logic [SPIN_W-1:0]  spin_ff, spin_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic [RAND_W-1:0]  rand_ff, rand_in;
   logic [SPIN_IW-1:0] j_ff, j_in;
   logic [ADDR_W-1:0]  r_ff, r_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic               pend_ff, pend_in;
   logic               psign_ff, psign_in;
   logic signed [6:0]  k_ff, k_in;
   logic [11:0]        f_ff, f_in;
   logic               over_ff, over_in;
   logic               flip_ff, flip_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SPIN_W-1:0]  rsp_spins_ff, rsp_spins_in;
   logic               rsp_flipped_ff, rsp_flipped_in;

   logic [CNT_W-1:0]   n_cnt;
   logic [CNT_W-1:0]   jx, px;
   logic               req_fire, pos_ok, last_j, slot_free, flip_ok;
   logic [ADDR_W-1:0]  rd_addr_w;
   logic [COEF_W-1:0]  rd_data;
   logic               ram_we;

   logic signed [MUL_AW-1:0] mul_a;
   logic signed [MUL_BW-1:0] mul_b;
   logic signed [PROD_W-1:0] prod;

   logic signed [ACC_W:0]    dval;
   logic signed [PROD_W-17:0] xfull;
   logic signed [17:0]       xc, nx;
   logic signed [18:0]       yval;
   logic [27:0]              poly_t;
   logic [16:0]              mval;
   logic [6:0]               negk;
   logic [39:0]              eval;
   logic [40:0]              dsum;
   logic signed [ACC_W-1:0]  rd_ext;

   // clamp of the active count: zero counts as one, the top at NUM_SPINS
   always_comb begin
      if (active_ff == '0) begin
         n_cnt = CNT_W'(1);
      end else if (32'(active_ff) > NUM_SPINS) begin
         n_cnt = CNT_W'(NUM_SPINS);
      end else begin
         n_cnt = CNT_W'(active_ff);
      end
   end

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign pos_ok    = CNT_W'(req_chan.spin_pos) < n_cnt;
   assign jx        = CNT_W'(j_ff);
   assign px        = CNT_W'(pos_ff);
   assign last_j    = (jx == n_cnt - CNT_W'(1));
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign rd_ext    = ACC_W'($signed(rd_data));
   assign flip_ok   = !over_ff && (rand_ff != '1)
                      && ($unsigned(prod) <= PROD_W'(ACC_LIMIT));

   ihb_ram #(
      .WIDTH (COEF_W),
      .DEPTH (COEF_DEPTH)
   ) u_coef_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (req_chan.coef_index[COEF_AW-1:0]),
      .wdata (req_chan.coef_value),
      .raddr (rd_addr_w[COEF_AW-1:0]),
      .rdata (rd_data)
   );

   ihb_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.func == FN_FLIP && pos_ok) begin
                  state_in = ST_SUM;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SUM: begin
            if (last_j) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:  state_in = ST_MUL_X;
         ST_MUL_X:  state_in = ST_CLAMP;
         ST_CLAMP:  state_in = ST_EXPF;
         ST_EXPF:   state_in = ST_POLY;
         ST_POLY:   state_in = ST_EXP;
         ST_EXP:    state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_FINISH;
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      active_in      = active_ff;
      spin_in        = spin_ff;
      pos_in         = pos_ff;
      scale_in       = scale_ff;
      rand_in        = rand_ff;
      j_in           = j_ff;
      r_in           = r_ff;
      acc_in         = acc_ff;
      pend_in        = pend_ff;
      psign_in       = psign_ff;
      k_in           = k_ff;
      f_in           = f_ff;
      over_in        = over_ff;
      flip_in        = flip_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_spins_in   = rsp_spins_ff;
      rsp_flipped_in = rsp_flipped_ff;
      ram_we         = 1'b0;
      rd_addr_w      = r_ff;
      mul_a          = '0;
      mul_b          = '0;
      dval           = '0;
      xfull          = '0;
      xc             = '0;
      nx             = '0;
      yval           = '0;
      poly_t         = '0;
      mval           = '0;
      negk           = '0;
      eval           = '0;
      dsum           = '0;

      if (csr_we) begin
         active_in = csr_wdata;
      end

      // pending coefficient from the previous read cycle
      if (pend_ff) begin
         acc_in = psign_ff ? acc_ff + rd_ext : acc_ff - rd_ext;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               pos_in   = req_chan.spin_pos;
               scale_in = req_chan.anneal_scale;
               rand_in  = req_chan.random_u;
               j_in     = '0;
               r_in     = '0;
               acc_in   = '0;
               pend_in  = 1'b0;
               flip_in  = 1'b0;
               case (req_chan.func)
                  FN_WRITE: ram_we  = 32'(req_chan.coef_index) < COEF_DEPTH;
                  FN_LOAD:  spin_in = req_chan.spin_word;
                  default:  ;
               endcase
            end
         end
         ST_SUM: begin
            // row start r tracks min(j, pos); the field sits in the j == pos slot
            if (jx == px) begin
               rd_addr_w = PAIR_BASE[n_cnt] + ADDR_W'(px);
            end else if (jx < px) begin
               rd_addr_w = r_ff + ADDR_W'(px) - ADDR_W'(jx) - ADDR_W'(1);
               r_in      = r_ff + ADDR_W'(n_cnt) - ADDR_W'(jx) - ADDR_W'(1);
            end else begin
               rd_addr_w = r_ff + ADDR_W'(jx) - ADDR_W'(px) - ADDR_W'(1);
            end
            pend_in  = 1'b1;
            psign_in = (jx == px) || spin_ff[j_ff];
            j_in     = j_ff + SPIN_IW'(1);
         end
         ST_DRAIN: begin
            pend_in = 1'b0;
         end
         ST_MUL_X: begin
            dval  = spin_ff[pos_ff] ? -{acc_ff, 1'b0} : {acc_ff, 1'b0};
            mul_a = MUL_AW'(dval);
            mul_b = $signed(MUL_BW'(scale_ff));
         end
         ST_CLAMP: begin
            xfull = prod[PROD_W-1:16];
            if (xfull < -(PROD_W-16)'(65536)) begin
               xc = -18'sd65536;
            end else if (xfull > (PROD_W-16)'(65536)) begin
               xc = 18'sd65536;
            end else begin
               xc = 18'(xfull);
            end
            nx    = -xc;
            mul_a = MUL_AW'(nx);
            mul_b = MUL_BW'(LOG2E_Q12);
         end
         ST_EXPF: begin
            yval  = prod[30:12];
            k_in  = yval[18:12];
            f_in  = yval[11:0];
            mul_a = $signed(MUL_AW'(yval[11:0]));
            mul_b = MUL_BW'(POLY_C2);
         end
         ST_POLY: begin
            poly_t = POLY_C1 + prod[27:0];
            mul_a  = $signed(MUL_AW'(poly_t));
            mul_b  = $signed(MUL_BW'(f_ff));
         end
         ST_EXP: begin
            mval = ONE_Q16 + 17'(prod[39:24]);
            negk = -k_ff;
            if (k_ff >= 0) begin
               eval = 40'(mval) << k_ff[4:0];
            end else begin
               eval = 40'(mval) >> negk[4:0];
            end
            dsum    = 41'(eval) + 41'(ONE_Q16);
            over_in = dsum > ACC_LIMIT;
            // u < floor(2^32 / d) is the same as (u + 1) * d <= 2^32
            mul_a   = $signed(MUL_AW'(dsum[32:0]));
            mul_b   = $signed(MUL_BW'(17'(rand_ff) + 17'd1));
         end
         ST_DECIDE: begin
            if (flip_ok) begin
               spin_in = spin_ff ^ (SPIN_W'(1) << pos_ff);
               flip_in = 1'b1;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_spins_in   = spin_ff;
               rsp_flipped_in = flip_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= ACTIVE_RESET;
         spin_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         spin_ff      <= spin_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff         <= pos_in;
      scale_ff       <= scale_in;
      rand_ff        <= rand_in;
      j_ff           <= j_in;
      r_ff           <= r_in;
      acc_ff         <= acc_in;
      psign_ff       <= psign_in;
      k_ff           <= k_in;
      f_ff           <= f_in;
      over_ff        <= over_in;
      flip_ff        <= flip_in;
      rsp_spins_ff   <= rsp_spins_in;
      rsp_flipped_ff <= rsp_flipped_in;
   end

   assign req_chan.ready  = (state_ff == ST_IDLE);
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.spins  = rsp_spins_ff;
   assign rsp_chan.flipped = rsp_flipped_ff;

   // store reads during the sum never leave the store
   a_sum_addr_in_store: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SUM |-> rd_addr_w < ADDR_W'(COEF_DEPTH))
      else $error("coefficient read beyond the store");

   // an accepted flip changes exactly one spin
   a_flip_one_bit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && flip_ok)
      |=> $countones(spin_ff ^ $past(spin_ff)) == 1)
      else $error("accepted flip did not change exactly one spin");

   // non-flip requests go straight to the response step
   a_short_path: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.func != FN_FLIP) |=> state_ff == ST_FINISH)
      else $error("write or load request took the long path");

endmodule

// ===== rtl/core/ihb_ram.sv =====
// ----------------------------------------------------------------------------
// ihb_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ihb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 136
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/ihb_mul.sv =====
// ----------------------------------------------------------------------------
// ihb_mul - shared signed multiplier with registered product
// Every multiply of the flip evaluation goes through this one unit.
// ----------------------------------------------------------------------------
module ihb_mul (
   input  logic                              clock,
   input  logic signed [ihb_pkg::MUL_AW-1:0] op_a,
   input  logic signed [ihb_pkg::MUL_BW-1:0] op_b,
   output logic signed [ihb_pkg::PROD_W-1:0] prod
);
   import ihb_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   always_comb begin
      prod_in = PROD_W'(op_a) * PROD_W'(op_b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule
